FILE: src/breakpoint_match_table_core_macros.svh
// ----------------------------------------------------------------------------
// Breakpoint match table assertion macros
// Shared property wrappers for the checker of the breakpoint table core.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_MATCH_TABLE_CORE_MACROS_SVH
`define BREAKPOINT_MATCH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BMT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BMT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bmt_pkg.sv
// ----------------------------------------------------------------------------
// Breakpoint match table package
// Request, response, entry and token types shared by the table modules.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int ADDR_W = 24;
    localparam int PERM_W = 3;
    localparam int CMD_W  = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] target_address;
        logic [PERM_W-1:0] new_perms;
    } bmt_req_t;

    typedef struct packed {
        logic [PERM_W-1:0] match_perms;
        logic              op_failed;
    } bmt_rsp_t;

    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] address;
        logic [PERM_W-1:0] perms;
    } bmt_entry_t;

    // A command as it walks the chain, with what it has seen so far.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [PERM_W-1:0] new_perms;
        logic              found;
        logic [PERM_W-1:0] hit_perms;
        logic              placed;
    } bmt_token_t;

endpackage

FILE: src/bmt_cell.sv
// ----------------------------------------------------------------------------
// Breakpoint match table cell
// Holds one table entry and applies a passing command token to it.
// ----------------------------------------------------------------------------
module bmt_cell
    import bmt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tok_in_valid,
    input  bmt_token_t tok_in,
    input  bmt_entry_t next_entry,
    output logic       tok_out_valid,
    output bmt_token_t tok_out,
    output bmt_entry_t entry
);

    logic              tok_valid_reg;
    bmt_token_t        tok_reg;
    logic              entry_valid_reg;
    logic              entry_valid_next;
    logic [PERM_W-1:0] entry_perms_reg;
    logic [PERM_W-1:0] entry_perms_next;
    logic [ADDR_W-1:0] entry_addr_reg;
    logic [ADDR_W-1:0] entry_addr_next;
    logic              match;
    logic              seen;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg   <= 1'b0;
            entry_valid_reg <= 1'b0;
            entry_perms_reg <= '0;
        end
        else
        begin
            tok_valid_reg   <= tok_in_valid;
            entry_valid_reg <= entry_valid_next;
            entry_perms_reg <= entry_perms_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in_valid)
        begin
            tok_reg <= tok_in;
        end
        entry_addr_reg <= entry_addr_next;
    end

    assign match = entry_valid_reg && (entry_addr_reg == tok_reg.address);
    assign seen  = tok_reg.found || match;

    always_comb
    begin
        entry_valid_next  = entry_valid_reg;
        entry_perms_next  = entry_perms_reg;
        entry_addr_next   = entry_addr_reg;
        tok_out           = tok_reg;
        tok_out.found     = seen;
        if (match)
        begin
            tok_out.hit_perms = entry_perms_reg;
        end
        if (tok_valid_reg)
        begin
            case (tok_reg.command)
                CMD_ADD:
                begin
                    if (match)
                    begin
                        entry_perms_next = tok_reg.new_perms;
                    end
                    else if (!entry_valid_reg && !tok_reg.found && !tok_reg.placed)
                    begin
                        // Valid entries are packed, so the first empty cell is the free slot.
                        entry_valid_next = 1'b1;
                        entry_addr_next  = tok_reg.address;
                        entry_perms_next = tok_reg.new_perms;
                        tok_out.placed   = 1'b1;
                    end
                end
                CMD_DELETE:
                begin
                    // The neighbor has not seen this token yet, so its entry is still intact.
                    if (seen)
                    begin
                        entry_valid_next = next_entry.valid;
                        entry_addr_next  = next_entry.address;
                        entry_perms_next = next_entry.perms;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tok_out_valid = tok_valid_reg;
    assign entry.valid   = entry_valid_reg;
    assign entry.address = entry_addr_reg;
    assign entry.perms   = entry_perms_reg;

endmodule

FILE: src/breakpoint_match_table_core.sv
// The command token walks the cell chain one entry per cycle. Only one request is in
// flight: the block takes no new request until the token has passed every cell and
// its response is registered.
// A new request is taken while the previous response still waits for rsp_ready.
// Reset (rst_n, asynchronous, active low) empties the table at once.
// ----------------------------------------------------------------------------
// Breakpoint match table core
// Compacted table of address breakpoints with lookup, add and delete,
// built as a chain of entry cells that a command token walks through.
// ----------------------------------------------------------------------------
module breakpoint_match_table_core
    import bmt_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  bmt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output bmt_rsp_t rsp
);

    logic       tok_valid [DEPTH+1];
    bmt_token_t tok       [DEPTH+1];
    bmt_entry_t entries   [DEPTH+1];

    logic       busy_reg;
    logic       busy_next;
    logic       end_valid_reg;
    logic       end_valid_next;
    bmt_token_t end_tok_reg;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    bmt_rsp_t   rsp_reg;
    bmt_rsp_t   rsp_next;
    logic       req_fire;
    logic       end_move;

    assign req_ready = !busy_reg;
    assign req_fire  = req_valid && req_ready;
    assign end_move  = end_valid_reg && (!rsp_valid_reg || rsp_ready);

    assign tok_valid[0]       = req_fire;
    assign tok[0].command     = req.command;
    assign tok[0].address     = req.target_address;
    assign tok[0].new_perms   = req.new_perms;
    assign tok[0].found       = 1'b0;
    assign tok[0].hit_perms   = '0;
    assign tok[0].placed      = 1'b0;
    assign entries[DEPTH]     = '0;

    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        bmt_cell u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .tok_in_valid  (tok_valid[k]),
            .tok_in        (tok[k]),
            .next_entry    (entries[k+1]),
            .tok_out_valid (tok_valid[k+1]),
            .tok_out       (tok[k+1]),
            .entry         (entries[k])
        );
    end

    always_comb
    begin
        busy_next      = busy_reg;
        end_valid_next = end_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (end_move)
        begin
            end_valid_next = 1'b0;
            busy_next      = 1'b0;
            rsp_valid_next = 1'b1;
            rsp_next.match_perms = ((end_tok_reg.command == CMD_LOOKUP) && end_tok_reg.found)
                                   ? end_tok_reg.hit_perms : '0;
            rsp_next.op_failed   =
                ((end_tok_reg.command == CMD_ADD) && !end_tok_reg.found && !end_tok_reg.placed)
                || ((end_tok_reg.command == CMD_DELETE) && !end_tok_reg.found);
        end
        if (tok_valid[DEPTH])
        begin
            end_valid_next = 1'b1;
        end
        if (req_fire)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            end_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            end_valid_reg <= end_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[DEPTH])
        begin
            end_tok_reg <= tok[DEPTH];
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: src/bmt_checker.sv
// ----------------------------------------------------------------------------
// Breakpoint match table checker
// Port-level assertions for the breakpoint table core, bound to the top level.
// ----------------------------------------------------------------------------
`include "breakpoint_match_table_core_macros.svh"

module bmt_checker
    import bmt_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input bmt_req_t req,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input bmt_rsp_t rsp
);

    // A stalled response must hold its value.
    `BMT_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled response changed")

    // Only one command is in the chain at a time.
    `BMT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_valid && req_ready, !req_ready, "second request taken while busy")

    // A failed command never reports permissions.
    `BMT_ASSERT_NOW(a_fail_no_perms, clk, rst_n, rsp_valid && rsp.op_failed, rsp.match_perms == 3'd0, "failed response carries permissions")

endmodule

bind breakpoint_match_table_core bmt_checker u_bmt_checker (.*);

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Breakpoint match table core testbench
// Runs a short list of directed commands, then random lookup, add, delete and
// unused-command traffic, mostly over a small pool of addresses. Both handshakes
// get random gaps and long receiver hold-offs. Every response is checked in order
// against a typed answer or a behavioral copy of the table that the testbench keeps.
// ----------------------------------------------------------------------------
module tb;
    import bmt_pkg::*;

    localparam int DEPTH       = 16;
    localparam int RANDOM_ITEMS = 830;
    localparam int POOL_SIZE   = 32;
    localparam int CYCLE_LIMIT = 400000;

    // The command code that the block ignores.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [PERM_W-1:0] perms;
        int                n_times;
        bit                typed_answer;
        logic [PERM_W-1:0] exp_perms;
        logic              exp_failed;
    } plan_row_t;

    logic     clk;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    bmt_req_t req       = '0;
    logic     req_ready;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    bmt_rsp_t rsp;

    // Behavioral copy of the table, packed at the front like the block.
    logic [ADDR_W-1:0] bp_address [DEPTH];
    logic [PERM_W-1:0] bp_perms [DEPTH];
    int                bp_used = 0;

    bmt_rsp_t          pending_answers [$];
    logic [ADDR_W-1:0] address_pool [POOL_SIZE];
    int                mismatch_count = 0;
    int                cycle_count = 0;
    bit                sender_quiet = 1'b0;

    plan_row_t directed_plan [24] = '{
        '{CMD_LOOKUP, 24'h000000, 3'd0, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_DELETE, 24'hFFFFFF, 3'd7, 1,  1'b1, 3'd0, 1'b1},
        '{CMD_UNUSED, 24'h123456, 3'd7, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_ADD,    24'h000000, 3'd7, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_ADD,    24'hFFFFFF, 3'd0, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'h000000, 3'd0, 1,  1'b1, 3'd7, 1'b0},
        '{CMD_LOOKUP, 24'hFFFFFF, 3'd7, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_ADD,    24'h000000, 3'd5, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'h000000, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_ADD,    24'h800100, 3'd3, 14, 1'b0, 3'd0, 1'b0},
        '{CMD_ADD,    24'hABCDEF, 3'd6, 1,  1'b1, 3'd0, 1'b1},
        '{CMD_ADD,    24'hFFFFFF, 3'd2, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'hFFFFFF, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_UNUSED, 24'hFFFFFF, 3'd0, 1,  1'b1, 3'd0, 1'b0},
        '{CMD_DELETE, 24'h000000, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'h80010D, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_ADD,    24'hABCDEF, 3'd6, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_DELETE, 24'h80010D, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_DELETE, 24'h80010D, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'h800100, 3'd0, 14, 1'b0, 3'd0, 1'b0},
        '{CMD_DELETE, 24'h800105, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'hABCDEF, 3'd0, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'h555555, 3'd7, 1,  1'b0, 3'd0, 1'b0},
        '{CMD_LOOKUP, 24'hAAAAAA, 3'd0, 1,  1'b0, 3'd0, 1'b0}
    };

    breakpoint_match_table_core #(
        .DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("breakpoint_match_table_core test failed");
            $finish;
        end
    end

    // Applies one command to the table copy and returns the answer it gives.
    function automatic bmt_rsp_t apply_breakpoint_command(input bmt_req_t r);
        bmt_rsp_t answer;
        int       hit;
        answer = '0;
        hit = -1;
        for (int k = 0; k < bp_used; k++)
        begin
            if (hit < 0 && bp_address[k] == r.target_address)
                hit = k;
        end
        case (r.command)
            CMD_LOOKUP:
            begin
                if (hit >= 0)
                    answer.match_perms = bp_perms[hit];
            end
            CMD_ADD:
            begin
                if (hit >= 0)
                    bp_perms[hit] = r.new_perms;
                else if (bp_used < DEPTH)
                begin
                    bp_address[bp_used] = r.target_address;
                    bp_perms[bp_used] = r.new_perms;
                    bp_used++;
                end
                else
                    answer.op_failed = 1'b1;
            end
            CMD_DELETE:
            begin
                if (hit >= 0)
                begin
                    // Later entries move down one slot and keep their order.
                    for (int k = hit; k < bp_used - 1; k++)
                    begin
                        bp_address[k] = bp_address[k + 1];
                        bp_perms[k] = bp_perms[k + 1];
                    end
                    bp_used--;
                end
                else
                    answer.op_failed = 1'b1;
            end
            default:
            begin
            end
        endcase
        return answer;
    endfunction

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (sender_quiet || pick < 60)
            return 0;
        else if (pick < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offers one request, waits for it to be taken, then records its answer.
    task automatic send_request(input bmt_req_t r, input bit typed_answer,
                                input bmt_rsp_t typed_rsp);
        bmt_rsp_t predicted;
        int       gap;
        req_valid <= 1'b1;
        req <= r;
        do
            @(posedge clk);
        while (!req_ready);
        predicted = apply_breakpoint_command(r);
        pending_answers.push_back(typed_answer ? typed_rsp : predicted);
        gap = pick_gap();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [ADDR_W-1:0] pick_address();
        if ($urandom_range(0, 9) == 0)
            return ADDR_W'($urandom());
        return address_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Odd phases lean toward delete so the table drains as well as fills.
    function automatic logic [CMD_W-1:0] pick_command(input bit drain_phase);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            return CMD_LOOKUP;
        else if (pick < (drain_phase ? 55 : 80))
            return CMD_ADD;
        else if (pick < 95)
            return CMD_DELETE;
        else
            return CMD_UNUSED;
    endfunction

    always @(posedge clk)
    begin
        bmt_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: response with none outstanding: perms %0d failed %0b",
                         $time, rsp.match_perms, rsp.op_failed);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (rsp.match_perms !== want.match_perms)
                begin
                    mismatch_count++;
                    $display("%0t: match_perms expected %0d actual %0d",
                             $time, want.match_perms, rsp.match_perms);
                end
                if (rsp.op_failed !== want.op_failed)
                begin
                    mismatch_count++;
                    $display("%0t: op_failed expected %0b actual %0b",
                             $time, want.op_failed, rsp.op_failed);
                end
            end
        end
    end

    // Response side: random stalls, calm stretches, and two long hold-offs
    // that let the block fill up and push back on the request side.
    initial
    begin
        int stall_left;
        int holdoff_left;
        int answered;
        int mode_left;
        bit quiet;
        int pick;
        stall_left = 0;
        holdoff_left = 0;
        answered = 0;
        mode_left = 0;
        quiet = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
            begin
                answered++;
                if (answered == 200 || answered == 600)
                    holdoff_left = 400;
            end
            if (mode_left == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                mode_left = $urandom_range(20, 100);
            end
            else
                mode_left--;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                rsp_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (quiet)
                rsp_ready <= 1'b1;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    rsp_ready <= 1'b1;
                else if (pick < 93)
                begin
                    stall_left = $urandom_range(1, 3) - 1;
                    rsp_ready <= 1'b0;
                end
                else
                begin
                    stall_left = $urandom_range(10, 40) - 1;
                    rsp_ready <= 1'b0;
                end
            end
        end
    end

    initial
    begin
        bmt_req_t  r;
        bmt_rsp_t  typed_rsp;
        plan_row_t row;
        address_pool[0] = 24'h000000;
        address_pool[1] = 24'hFFFFFF;
        for (int k = 2; k < POOL_SIZE; k++)
            address_pool[k] = ADDR_W'($urandom());
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            for (int n = 0; n < row.n_times; n++)
            begin
                r.command = row.command;
                r.target_address = row.address + ADDR_W'(n);
                r.new_perms = row.perms;
                typed_rsp.match_perms = row.exp_perms;
                typed_rsp.op_failed = row.exp_failed;
                send_request(r, row.typed_answer, typed_rsp);
            end
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            r.command = pick_command((i / 100) % 2 == 1);
            r.target_address = pick_address();
            r.new_perms = PERM_W'($urandom_range(0, 7));
            send_request(r, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);

        if (mismatch_count == 0)
            $display("breakpoint_match_table_core test passed");
        else
            $display("breakpoint_match_table_core test failed");
        $finish;
    end

endmodule
